// File: rtl/multi_threshold_crossing_detector_defines.svh
// assertion macros used by the threshold crossing detector checker
`ifndef MULTI_THRESHOLD_CROSSING_DETECTOR_DEFINES_SVH
`define MULTI_THRESHOLD_CROSSING_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MTCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MTCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mtcd_pkg.sv
// types and constants of the threshold crossing detector
package mtcd_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int PAIR_REGS      = 4;
    localparam int THRESH_PAIRS   = 4;
    localparam int NUM_CHECKED    = (THRESH_PAIRS < PAIR_REGS) ? THRESH_PAIRS : PAIR_REGS;
    localparam int CFG_INDEX_W    = $clog2(PAIR_REGS + 1);
    localparam int CFG_DATA_W     = 2 * SAMPLE_W + 1;
    localparam int IN_TDATA_W     = ((SAMPLE_W + 7) / 8) * 8;
    localparam int RESULT_W       = SAMPLE_W + 2;
    localparam int OUT_TDATA_W    = ((RESULT_W + 7) / 8) * 8;
    localparam int RESULT_PAD_W   = OUT_TDATA_W - RESULT_W;

    // register indexes
    localparam int REG_MONITOR_ENABLE = 0;
    localparam int REG_PAIR_BASE      = 1;

    localparam logic signed [SAMPLE_W-1:0] LEVEL_AT_RESET = SAMPLE_W'(-9999);

    // one threshold pair register, bit 32 valid, high above low
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] lo;
    } pair_t;

    // result word as it sits on the output bus, changed flag in bit 0
    typedef struct packed {
        logic [RESULT_PAD_W-1:0]    pad;
        logic                       upward;
        logic signed [SAMPLE_W-1:0] level;
        logic                       changed;
    } result_t;

endpackage

// File: rtl/multi_threshold_crossing_detector.sv
// multi-level threshold crossing detector, top level
//
// usage
// - input stream s_*: one signed 16-bit temperature sample per request
// - output stream m_*: one result per sample, in order: changed flag,
//   last crossed threshold level and its direction
// - config channel cfg_*: index 0 monitor enable, index 1..4 threshold
//   pairs (bit 32 valid, bits 31:16 high, bits 15:0 low); always ready,
//   unknown indexes are dropped; write only while the block is idle
// - path: each sample passes the input register, then the result register, before its
//   result shows on m_tvalid
// - throughput: one sample per cycle while m_tready is high; the crossing search is a single
//   compare-and-select pass over the four pairs between the two registers
// - reset: history cleared, remembered level -9999 upward, monitoring off,
//   all pairs invalid
// - stall: while a result waits with m_tready low the result register holds; the input
//   register still takes one more sample, then s_tready drops
module multi_threshold_crossing_detector
    import mtcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input samples
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] temp_sample
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] crossing_changed, [16:1] crossed_level,
                                              // [17] crossed_upward, [23:18] zero
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration
    logic  monitor_enable_reg;
    pair_t pair_reg [PAIR_REGS];

    // input stage
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;

    // history
    logic                       sample_seen_reg;   // at least one sample taken
    logic signed [SAMPLE_W-1:0] prev_sample_reg;
    logic signed [SAMPLE_W-1:0] last_level_reg;
    logic                       last_upward_reg;

    // output stage
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic                       advance;
    logic                       step;
    logic                       s_fire;
    logic                       cfg_fire;
    logic signed [SAMPLE_W-1:0] level_next;
    logic                       upward_next;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // input register moves on whenever the result register is free or draining
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monitor_enable_reg <= 1'b0;
            for (int i = 0; i < PAIR_REGS; i++)
            begin
                pair_reg[i] <= '0;
            end
        end
        else if (cfg_fire)
        begin
            if (cfg_index == CFG_INDEX_W'(REG_MONITOR_ENABLE))
            begin
                monitor_enable_reg <= cfg_data[0];
            end
            for (int i = 0; i < PAIR_REGS; i++)
            begin
                if (cfg_index == CFG_INDEX_W'(REG_PAIR_BASE + i))
                begin
                    pair_reg[i] <= cfg_data;
                end
            end
        end
    end

    // crossing search: highest high crossed upward, else lowest low crossed downward;
    // on the first sample only highs at or below the sample count
    always_comb
    begin
        logic                       first;
        logic                       repeated;
        logic                       up_found;
        logic                       down_found;
        logic signed [SAMPLE_W-1:0] up_val;
        logic signed [SAMPLE_W-1:0] down_val;
        logic                       hit_up;
        logic                       hit_down;

        first      = !sample_seen_reg;
        repeated   = sample_seen_reg && (in_sample_reg == prev_sample_reg);
        up_found   = 1'b0;
        down_found = 1'b0;
        up_val     = '0;
        down_val   = '0;

        for (int i = 0; i < NUM_CHECKED; i++)
        begin
            hit_up   = pair_reg[i].valid && (in_sample_reg >= pair_reg[i].hi)
                       && (first || (pair_reg[i].hi > prev_sample_reg));
            hit_down = pair_reg[i].valid && !first && (in_sample_reg < pair_reg[i].lo)
                       && (pair_reg[i].lo <= prev_sample_reg);
            if (hit_up && (!up_found || (pair_reg[i].hi > up_val)))
            begin
                up_val   = pair_reg[i].hi;
                up_found = 1'b1;
            end
            if (hit_down && (!down_found || (pair_reg[i].lo < down_val)))
            begin
                down_val   = pair_reg[i].lo;
                down_found = 1'b1;
            end
        end

        level_next  = last_level_reg;
        upward_next = last_upward_reg;
        if (monitor_enable_reg && !repeated)
        begin
            if (up_found)
            begin
                level_next  = up_val;
                upward_next = 1'b1;
            end
            else if (down_found)
            begin
                level_next  = down_val;
                upward_next = 1'b0;
            end
        end

        result_next.pad     = '0;
        result_next.changed = (level_next != last_level_reg)
                              || (upward_next != last_upward_reg);
        result_next.level   = level_next;
        result_next.upward  = upward_next;
    end

    // control and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            sample_seen_reg <= 1'b0;
            prev_sample_reg <= '0;
            last_level_reg  <= LEVEL_AT_RESET;
            last_upward_reg <= 1'b1;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg   <= 1'b1;
                sample_seen_reg <= 1'b1;
                prev_sample_reg <= in_sample_reg;
                last_level_reg  <= level_next;
                last_upward_reg <= upward_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: rtl/mtcd_checker.sv
// port-level checks of the threshold crossing detector and their binding
`include "multi_threshold_crossing_detector_defines.svh"

module mtcd_checker
    import mtcd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic s_fire;
    logic m_stall;

    assign s_fire  = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    // a stalled result stays up
    `MTCD_ASSERT_NEXT(a_result_held, m_stall, m_tvalid, "result dropped while stalled")

    // a stalled result keeps its value
    `MTCD_ASSERT_NEXT(a_result_stable, m_stall, $stable(m_tdata), "result changed while stalled")

    // the input side only backs up when the output side is stalled
    `MTCD_ASSERT_SAME(a_ready_backpressure, !s_tready, m_stall, "input not ready without stall")

    // a result from an empty output appears only after a sample request has passed the input register
    `MTCD_ASSERT_SAME(a_result_latency, $rose(m_tvalid), $past(s_fire, 2), "orphan result")

endmodule

bind multi_threshold_crossing_detector mtcd_checker u_mtcd_checker (.*);
